// ----- rtl/core/linear_probe_key_set_assert.svh -----
// Assertion macros shared by the checker of the linear-probe key set.
// No dependencies; take in by `include where assertions are written.
`ifndef LINEAR_PROBE_KEY_SET_ASSERT_SVH
`define LINEAR_PROBE_KEY_SET_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define LPKS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, quiet while reset is high.
`define LPKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication that is also checked across reset.
`define LPKS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/core/lpks_pkg.sv -----
// Package of the linear-probe key set: operation codes, queue entry and
// response types, hash, size and register address constants. No dependencies.
`default_nettype none

package lpks_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
   } entry_type;

   typedef struct packed {
      logic present;
      logic status;
   } rsp_type;

   localparam logic [31:0] HASH_MUL = 32'd2654435761;
   localparam logic [4:0]  MIN_LOG2 = 5'd4;
   localparam logic [1:0]  REG_ADDR_TABLE_SIZE = 2'd0;
   localparam logic [3:0]  TABLE_SIZE_RESET = 4'd10;

endpackage

`default_nettype wire

// ----- rtl/core/linear_probe_key_set.sv -----
// Linear-probe key set: each command pulsed on start (while busy is low) is
// queued in a two-entry queue behind a hash front end and carried out by a
// probe sequencer over a slot memory with one write port and one registered
// read port. A lookup or insert reads one slot per cycle through the memory
// read port, starting at the home slot and stopping on a hit, a free slot or
// after a full sweep of the active size. A clear wipes all 2**ADDR_W slots
// (1024 by default) one per cycle; the same sweep runs after reset, busy held
// high while it lasts. busy is also high while the queue is full. Each
// result appears on rsp_present and rsp_status for exactly one cycle with
// rsp_valid high; the receiver cannot stall it. Depends on lpks_pkg,
// lpks_front, lpks_queue and lpks_back.
`default_nettype none

module linear_probe_key_set import lpks_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   output logic             rsp_present,
   output logic             rsp_status,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int ADDR_W  = $clog2(MAX_SLOTS + 1) - 1;
   localparam int ENTRY_W = $bits(entry_type) + ADDR_W;

   logic [3:0]         size_log2_ff;
   logic [4:0]         size_lg;
   logic [ADDR_W-1:0]  mask;

   logic               push;
   entry_type          push_entry;
   logic [ADDR_W-1:0]  push_home;
   logic               queue_full;
   logic               queue_empty;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   entry_type          pop_entry;
   logic [ADDR_W-1:0]  pop_home;
   logic               init_busy;
   rsp_type            rsp;

   // configuration register; only the word select bit decodes
   assign pready = 1'b1;
   assign prdata = {28'd0, size_log2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= TABLE_SIZE_RESET;
      end else if (psel && penable && pwrite && pready &&
                   (paddr[2] == REG_ADDR_TABLE_SIZE[0])) begin
         size_log2_ff <= pwdata[3:0];
      end
   end

   // clamp the size between MIN_LOG2 and what the memory holds, then build the slot mask
   always_comb begin
      if ({1'b0, size_log2_ff} < MIN_LOG2) begin
         size_lg = MIN_LOG2;
      end else if ({1'b0, size_log2_ff} > 5'(ADDR_W)) begin
         size_lg = 5'(ADDR_W);
      end else begin
         size_lg = {1'b0, size_log2_ff};
      end
      for (int i = 0; i < ADDR_W; i++) begin
         mask[i] = (5'(i) < size_lg);
      end
   end

   lpks_front #(.ADDR_W(ADDR_W)) u_front (
      .start         (start),
      .req_operation (req_operation),
      .req_key       (req_key),
      .mask          (mask),
      .queue_full    (queue_full),
      .init_busy     (init_busy),
      .busy          (busy),
      .push          (push),
      .push_entry    (push_entry),
      .push_home     (push_home)
   );

   lpks_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_entry, push_home}),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign pop_entry = entry_type'(pop_data[ENTRY_W-1:ADDR_W]);
   assign pop_home  = pop_data[ADDR_W-1:0];

   lpks_back #(.ADDR_W(ADDR_W)) u_back (
      .clock       (clock),
      .reset       (reset),
      .mask        (mask),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop_home    (pop_home),
      .pop         (pop),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_present = rsp.present;
   assign rsp_status  = rsp.status;

endmodule

`default_nettype wire

// ----- rtl/core/lpks_front.sv -----
// Front end of the linear-probe key set: takes commands, works out the
// home slot by multiplicative hash and pushes them to the queue. Uses lpks_pkg.
`default_nettype none

module lpks_front import lpks_pkg::*; #(
   parameter int ADDR_W = 10
) (
   input  wire logic              start,
   input  wire logic [1:0]        req_operation,
   input  wire logic [31:0]       req_key,
   input  wire logic [ADDR_W-1:0] mask,
   input  wire logic              queue_full,
   input  wire logic              init_busy,
   output logic                   busy,
   output logic                   push,
   output entry_type              push_entry,
   output logic [ADDR_W-1:0]      push_home
);

   logic [31:0] product;

   // hold off new commands while the queue is full or the table is being wiped
   assign busy = queue_full | init_busy;
   assign push = start & ~busy;

   assign product         = req_key * HASH_MUL;
   assign push_home       = product[ADDR_W-1:0] & mask;
   assign push_entry.op   = op_type'(req_operation);
   assign push_entry.key  = req_key;

endmodule

`default_nettype wire

// ----- rtl/core/lpks_queue.sv -----
// Two-entry command queue between front and back of the key set.
// Generic payload; does not use lpks_pkg.
`default_nettype none

module lpks_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/lpks_back.sv -----
// Back end of the key set: slot memory, probe sequencer, clearing sweep
// and response register. Uses lpks_pkg.
`default_nettype none

module lpks_back import lpks_pkg::*; #(
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ADDR_W-1:0] mask,
   input  wire logic              queue_empty,
   input  wire entry_type         pop_entry,
   input  wire logic [ADDR_W-1:0] pop_home,
   output logic                   pop,
   output logic                   init_busy,
   output logic                   rsp_valid,
   output rsp_type                rsp
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CLEAR = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   localparam int DEPTH = 1 << ADDR_W;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   op_type            op_ff, op_in;
   logic [31:0]       key_ff, key_in;
   logic              init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [32:0]       slot_mem [DEPTH];
   logic [32:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] next_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [32:0]       wr_data;
   logic              slot_valid;
   logic              slot_hit;

   assign next_addr  = ADDR_W'(addr_ff + 1'b1) & mask;
   assign rd_addr    = (state_ff == ST_IDLE) ? pop_home : next_addr;
   assign slot_valid = rd_data_ff[32];
   assign slot_hit   = slot_valid && (rd_data_ff[31:0] == key_ff);
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      init_in      = init_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               op_in  = pop_entry.op;
               key_in = pop_entry.key;
               case (pop_entry.op)
                  OP_LOOKUP, OP_INSERT: begin
                     state_in = ST_CHECK;
                     addr_in  = pop_home;
                     count_in = '0;
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     addr_in  = '0;
                  end
                  default: begin
                     // unused code: answer at once, touch nothing
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = ADDR_W'(addr_ff + 1'b1);
            if (addr_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
               if (init_ff) begin
                  init_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (!slot_valid) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_INSERT) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, key_ff};
               end
            end else if (slot_hit) begin
               rsp_valid_in   = 1'b1;
               rsp_in.present = 1'b1;
               state_in       = ST_IDLE;
            end else if (count_ff == mask) begin
               // full sweep without a match or a free slot
               rsp_valid_in  = 1'b1;
               rsp_in.status = (op_ff == OP_INSERT);
               state_in      = ST_IDLE;
            end else begin
               addr_in  = next_addr;
               count_in = ADDR_W'(count_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      op_ff    <= op_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lpks_checker.sv -----
// Port-level checks of the linear-probe key set and the bind that attaches
// them to the top level. Uses linear_probe_key_set_assert.svh.
`default_nettype none

`include "linear_probe_key_set_assert.svh"

module lpks_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_present,
   input wire logic        rsp_status,
   input wire logic        psel,
   input wire logic        penable,
   input wire logic        pwrite,
   input wire logic [2:0]  paddr,
   input wire logic [31:0] pwdata,
   input wire logic [31:0] prdata
);

   logic size_write;

   assign size_write = psel && penable && pwrite && !paddr[2];

   // a full table never reports the key as present
   `LPKS_ASSERT_IMPL(a_full_not_present, clock, reset, rsp_valid && rsp_status, !rsp_present)

   // reset starts the wiping sweep, during which nothing is taken
   `LPKS_ASSERT_NEXT_ALWAYS(a_reset_busy, clock, reset, busy)

   // no stray result straight out of reset
   `LPKS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // a size write reads back in the next cycle
   `LPKS_ASSERT_NEXT(a_size_readback, clock, reset, size_write, prdata == 32'($past(pwdata[3:0])))

endmodule

bind linear_probe_key_set lpks_checker u_lpks_checker (
   .clock       (clock),
   .reset       (reset),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_present (rsp_present),
   .rsp_status  (rsp_status),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);

`default_nettype wire

// ----- bench/key_set_checker.sv -----
// Checker for the linear-probe key set: keeps a shadow slot table and table size,
// works out the result of each accepted command and compares it with the block's.
// Depends on lpks_pkg.
module key_set_checker import lpks_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key,
   input  logic        rsp_valid,
   input  logic        rsp_present,
   input  logic        rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          mismatch_count,
   output int          open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] SIZE_ADDR = 3'(REG_ADDR_TABLE_SIZE) << 2;
   // log2 of the largest power of two not above MAX_SLOTS
   localparam int unsigned TOP_LOG2 = $clog2(MAX_SLOTS + 1) - 1;

   logic [31:0] stored_key [MAX_SLOTS];
   logic        stored_used [MAX_SLOTS];
   logic [3:0]  size_log2;
   rsp_type     due_rsps [$];
   rsp_type     due_rsp;
   int          fail_total = 0;

   initial begin
      mismatch_count = 0;
      open_count = 0;
   end

   function automatic void wipe_store();
      for (int i = 0; i < MAX_SLOTS; i++) begin
         stored_key[i] = '0;
         stored_used[i] = 1'b0;
      end
   endfunction

   // Carry out one command on the shadow table and return its result.
   function automatic rsp_type apply_cmd(input logic [1:0] op, input logic [31:0] key);
      rsp_type     outcome;
      int unsigned lg;
      int unsigned mask;
      int unsigned idx;
      logic [31:0] hashed;
      bit          found;
      bit          open_slot;
      outcome = '0;
      lg = (size_log2 < MIN_LOG2) ? MIN_LOG2 : size_log2;
      if (lg > TOP_LOG2) lg = TOP_LOG2;
      mask = (1 << lg) - 1;
      hashed = key * HASH_MUL;
      idx = hashed & mask;
      found = 1'b0;
      open_slot = 1'b0;
      if (op == OP_LOOKUP || op == OP_INSERT) begin
         // stop on a hit, an empty slot, or after one full sweep
         for (int unsigned n = 0; n <= mask && !found && !open_slot; n++) begin
            if (!stored_used[idx]) open_slot = 1'b1;
            else if (stored_key[idx] == key) found = 1'b1;
            else idx = (idx + 1) & mask;
         end
         outcome.present = found;
         if (op == OP_INSERT && !found) begin
            if (open_slot) begin
               stored_key[idx] = key;
               stored_used[idx] = 1'b1;
            end else begin
               outcome.status = 1'b1;
            end
         end
      end else if (op == OP_CLEAR) begin
         wipe_store();
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wipe_store();
         size_log2 = TABLE_SIZE_RESET;
         due_rsps.delete();
      end else begin
         // match results before taking in a new command on the same edge
         if (rsp_valid) begin
            if (due_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual present %0b status %0b",
                        $time, rsp_present, rsp_status);
               fail_total++;
            end else begin
               due_rsp = due_rsps.pop_front();
               if (rsp_present !== due_rsp.present) begin
                  $display("%0t: present mismatch, expected %0b, actual %0b",
                           $time, due_rsp.present, rsp_present);
                  fail_total++;
               end
               if (rsp_status !== due_rsp.status) begin
                  $display("%0t: status mismatch, expected %0b, actual %0b",
                           $time, due_rsp.status, rsp_status);
                  fail_total++;
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
            size_log2 = pwdata[3:0];
         if (start && !busy)
            due_rsps.push_back(apply_cmd(req_operation, req_key));
      end
      open_count <= due_rsps.size();
      mismatch_count <= fail_total;
   end

endmodule

// ----- bench/tb_linear_probe_key_set.sv -----
// Top of the linear-probe key set bench: clock, reset, commands and size writes,
// with the checker alongside the block. Depends on lpks_pkg, key_set_checker and the RTL.
module tb_linear_probe_key_set import lpks_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] SIZE_ADDR = 3'(REG_ADDR_TABLE_SIZE) << 2;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POOL_MAX = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_operation = OP_LOOKUP;
   logic [31:0] req_key = '0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_present;
   logic        rsp_status;
   logic [31:0] prdata;
   logic        pready;
   int          mismatch_count;
   int          open_count;

   // sizes per random phase; 0, 3 and 15 lie outside the legal range
   logic [3:0]  size_plan [12] = '{4'd5, 4'd10, 4'd4, 4'd7, 4'd15, 4'd6,
                                   4'd3, 4'd8, 4'd5, 4'd9, 4'd0, 4'd10};
   logic [31:0] key_pool [POOL_MAX];

   always #5 clock = ~clock;

   linear_probe_key_set dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_present   (rsp_present),
      .rsp_status    (rsp_status),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   key_set_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_present    (rsp_present),
      .rsp_status     (rsp_status),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   // Present one command and hold it until the block takes it; start stays high.
   task automatic issue(input logic [1:0] op, input logic [31:0] key);
      start <= 1'b1;
      req_operation <= op;
      req_key <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and hold until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [3:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SIZE_ADDR;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Mostly back to back, some short gaps, a few long ones, now and then a full drain.
   task automatic idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         drain();
      end else if (pick >= 60) begin
         start <= 1'b0;
         if (pick < 92) repeat ($urandom_range(1, 3)) @(posedge clock);
         else repeat ($urandom_range(10, 60)) @(posedge clock);
      end
   endtask

   initial begin
      int unsigned lg;
      int          pool_n;
      int          pick;
      bit          steady;
      logic [31:0] key;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: duplicate insert, unused code, clear
      issue(OP_LOOKUP, 32'h0);
      issue(OP_INSERT, 32'h0);
      issue(OP_INSERT, 32'h0);
      issue(OP_UNUSED, '1);
      issue(OP_CLEAR, '1);
      drain();

      // size below range saturates to 16 slots; fill it, then overfill
      write_table_size(4'd0);
      issue(OP_INSERT, '1);
      issue(OP_INSERT, 32'h0);
      for (int k = 1; k <= 14; k++) issue(OP_INSERT, k * 32'h0101_0101);
      issue(OP_INSERT, 32'h1234_5678);
      issue(OP_LOOKUP, 32'hDEAD_BEEF);
      issue(OP_INSERT, 32'h0);
      drain();

      // size above range saturates to the full store; no clear, so old keys may hide
      write_table_size(4'd15);
      issue(OP_LOOKUP, '1);
      issue(OP_LOOKUP, 32'h0);

      foreach (size_plan[p]) begin
         drain();
         write_table_size(size_plan[p]);
         if ($urandom_range(0, 4) != 0) issue(OP_CLEAR, $urandom());
         lg = (size_plan[p] < MIN_LOG2) ? MIN_LOG2 : size_plan[p];
         if (lg > 10) lg = 10;
         // a pool a little larger than the table drives small tables to full
         pool_n = (1 << lg) + 4;
         if (pool_n > POOL_MAX) pool_n = POOL_MAX;
         foreach (key_pool[i]) key_pool[i] = $urandom();
         steady = (p % 3 == 1);
         repeat (78) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) != 0) key = key_pool[$urandom_range(0, pool_n - 1)];
            else key = $urandom();
            if (pick < 45) issue(OP_INSERT, key);
            else if (pick < 92) issue(OP_LOOKUP, key);
            else if (pick < 95) issue(OP_CLEAR, key);
            else issue(OP_UNUSED, key);
            if (!steady) idle_gap();
         end
      end

      drain();
      // allow for a clear-length sweep in case a stray result follows
      repeat (1100) @(posedge clock);
      if (mismatch_count == 0 && open_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lpks_pkg.sv
rtl/core/lpks_front.sv
rtl/core/lpks_queue.sv
rtl/core/lpks_back.sv
rtl/core/linear_probe_key_set.sv
rtl/core/lpks_checker.sv
bench/key_set_checker.sv
bench/tb_linear_probe_key_set.sv
